[src/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Condition checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`endif

[src/corx_pkg.sv]
// Package: types, constants and tables of the cross obstacle transform.
`default_nettype none
package corx_pkg;
  localparam int SEG_COUNT = 12;
  localparam int CORDIC_STEPS = 16;
  localparam logic signed [33:0] CORDIC_GAIN_INIT = 34'sd652032875;
  localparam logic [2:0] QDEPTH_LOG = 3'd2;

  localparam logic [1:0] REG_HALF_WIDTH = 2'd0;
  localparam logic [1:0] REG_ARM_LENGTH = 2'd1;
  localparam logic [1:0] REG_OFFSET_X   = 2'd2;
  localparam logic [1:0] REG_OFFSET_Y   = 2'd3;

  typedef enum logic {ACT_REBUILD = 1'b0, ACT_MOVE = 1'b1} action_t;

  typedef struct packed {
    logic        move;
    logic [31:0] mx;
    logic [31:0] my;
    logic [17:0] cos_v;
    logic [17:0] sin_v;
  } cmd_t;

  typedef enum logic [1:0] {FR_IDLE, FR_CORDIC, FR_PUSH} front_state_t;
  typedef enum logic [2:0] {BK_IDLE, BK_CALC, BK_MUL, BK_WRITE, BK_EMIT} back_state_t;

  function automatic logic [31:0] atan_turn(input logic [3:0] i);
    case (i)
      4'd0: atan_turn = 32'd536870912;
      4'd1: atan_turn = 32'd316933406;
      4'd2: atan_turn = 32'd167458907;
      4'd3: atan_turn = 32'd85004756;
      4'd4: atan_turn = 32'd42667331;
      4'd5: atan_turn = 32'd21354465;
      4'd6: atan_turn = 32'd10679838;
      4'd7: atan_turn = 32'd5340245;
      4'd8: atan_turn = 32'd2670163;
      4'd9: atan_turn = 32'd1335087;
      4'd10: atan_turn = 32'd667544;
      4'd11: atan_turn = 32'd333772;
      4'd12: atan_turn = 32'd166886;
      4'd13: atan_turn = 32'd83443;
      4'd14: atan_turn = 32'd41722;
      4'd15: atan_turn = 32'd20861;
      default: atan_turn = 32'd0;
    endcase
  endfunction

  // corner code: 0 = -l, 1 = -w, 2 = +w, 3 = +l; bx, by, ex, ey
  function automatic logic [7:0] outline_code(input logic [3:0] k);
    case (k)
      4'd0: outline_code = {2'd1, 2'd3, 2'd2, 2'd3};
      4'd1: outline_code = {2'd2, 2'd3, 2'd2, 2'd2};
      4'd2: outline_code = {2'd2, 2'd2, 2'd3, 2'd2};
      4'd3: outline_code = {2'd3, 2'd2, 2'd3, 2'd1};
      4'd4: outline_code = {2'd3, 2'd1, 2'd2, 2'd1};
      4'd5: outline_code = {2'd2, 2'd1, 2'd2, 2'd0};
      4'd6: outline_code = {2'd2, 2'd0, 2'd1, 2'd0};
      4'd7: outline_code = {2'd1, 2'd0, 2'd1, 2'd1};
      4'd8: outline_code = {2'd1, 2'd1, 2'd0, 2'd1};
      4'd9: outline_code = {2'd0, 2'd1, 2'd0, 2'd2};
      4'd10: outline_code = {2'd0, 2'd2, 2'd1, 2'd2};
      4'd11: outline_code = {2'd1, 2'd2, 2'd1, 2'd3};
      default: outline_code = 8'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

[src/corx_front.sv]
// Front end: accepts items, runs the sine/cosine CORDIC for move items and queues commands.
`default_nettype none
`include "assert_macros.svh"
module corx_front
  import corx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        action,
  input  wire logic [31:0] move_x,
  input  wire logic [31:0] move_y,
  input  wire logic [15:0] turn_angle,
  output logic             cmd_valid,
  input  wire logic        cmd_take,
  output cmd_t             cmd
);
  front_state_t state, state_next;
  logic signed [33:0] cx, cy;
  logic signed [32:0] cz;
  logic [3:0] step;
  logic flip;
  cmd_t hold;
  cmd_t qin;
  logic [QDEPTH_LOG-1:0] wp, rp;
  logic [QDEPTH_LOG:0] cnt;
  cmd_t q [2**QDEPTH_LOG];
  logic qfull, qpush;
  logic [31:0] a32;
  logic signed [33:0] cfin, sfin, rx, ry;

  assign qfull = cnt == (QDEPTH_LOG+1)'(2**QDEPTH_LOG);
  assign full = state != FR_IDLE;
  assign cmd_valid = cnt != '0;
  assign cmd = q[rp];
  assign a32 = {turn_angle, 16'd0};

  always_comb begin
    state_next = state;
    case (state)
      FR_IDLE: if (push) state_next = (action == ACT_MOVE) ? FR_CORDIC : FR_PUSH;
      FR_CORDIC: if (step == 4'd15) state_next = FR_PUSH;
      FR_PUSH: if (!qfull) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    qpush = (state == FR_PUSH) && !qfull;
    rx = flip ? -cx : cx;
    ry = flip ? -cy : cy;
    cfin = (rx + 34'sd8192) >>> 14;
    sfin = (ry + 34'sd8192) >>> 14;
    qin = hold;
    if (hold.move) begin
      qin.cos_v = cfin[17:0];
      qin.sin_v = sfin[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (qpush) wp <= wp + 1'b1;
      if (cmd_take && cmd_valid) rp <= rp + 1'b1;
      cnt <= cnt + (QDEPTH_LOG+1)'(qpush) - (QDEPTH_LOG+1)'(cmd_take && cmd_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (qpush) q[wp] <= qin;
    case (state)
      FR_IDLE: begin
        if (push) begin
          hold.move <= action;
          hold.mx <= move_x;
          hold.my <= move_y;
          hold.cos_v <= '0;
          hold.sin_v <= '0;
          flip <= a32[31:30] == 2'd1 || a32[31:30] == 2'd2;
          cx <= CORDIC_GAIN_INIT;
          cy <= '0;
          step <= '0;
          if (a32[31:30] == 2'd1 || a32[31:30] == 2'd2)
            cz <= 33'(signed'(a32 + 32'h8000_0000));
          else
            cz <= 33'(signed'(a32));
        end
      end
      FR_CORDIC: begin
        step <= step + 1'b1;
        if (!cz[32]) begin
          cx <= cx - (cy >>> step);
          cy <= cy + (cx >>> step);
          cz <= cz - signed'({1'b0, atan_turn(step)});
        end else begin
          cx <= cx + (cy >>> step);
          cy <= cy - (cx >>> step);
          cz <= cz + signed'({1'b0, atan_turn(step)});
        end
      end
      default: ;
    endcase
  end

  `ASSERT_IMPL(a_push_not_full, clk, rst, qpush, cnt < (QDEPTH_LOG+1)'(2**QDEPTH_LOG),
    "command queue overrun")
  `ASSERT_IMPL(a_busy_full, clk, rst, state == FR_CORDIC, full, "front accepts while busy")
  `ASSERT_ALWAYS(a_cnt_range, clk, rst, cnt <= (QDEPTH_LOG+1)'(2**QDEPTH_LOG), "bad count")
endmodule
`default_nettype wire

[src/corx_back.sv]
// Back end: segment store, rebuild and rotate/translate, result output.
`default_nettype none
`include "assert_macros.svh"
module corx_back
  import corx_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_take,
  input  cmd_t             cmd,
  input  wire logic [29:0] half_width,
  input  wire logic [29:0] arm_length,
  input  wire logic [30:0] offset_x,
  input  wire logic [30:0] offset_y,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       segment_index,
  output logic [31:0]      begin_x,
  output logic [31:0]      begin_y,
  output logic [31:0]      end_x,
  output logic [31:0]      end_y,
  output logic [31:0]      center_x,
  output logic [31:0]      center_y,
  output logic             last_segment
);
  localparam int CW = COORD_WIDTH;
  back_state_t state, state_next;
  logic [CW-1:0] bxs [SEG_COUNT];
  logic [CW-1:0] bys [SEG_COUNT];
  logic [CW-1:0] exs [SEG_COUNT];
  logic [CW-1:0] eys [SEG_COUNT];
  logic [CW-1:0] cnx, cny;
  cmd_t cur;
  logic [3:0] seg;
  logic pt;
  logic signed [CW-1:0] px, py;
  logic signed [CW+17:0] pxc, pys, pxs, pyc;
  logic signed [CW+19:0] rxw, ryw;
  logic [CW-1:0] nx, ny;
  logic signed [CW-1:0] vals [4];
  logic segdone;

  assign segdone = seg == 4'(SEG_COUNT-1);
  assign cmd_take = state == BK_IDLE && cmd_valid;
  assign empty = state != BK_EMIT;
  assign segment_index = seg;
  assign begin_x = 32'(signed'(bxs[seg]));
  assign begin_y = 32'(signed'(bys[seg]));
  assign end_x = 32'(signed'(exs[seg]));
  assign end_y = 32'(signed'(eys[seg]));
  assign center_x = 32'(signed'(cnx));
  assign center_y = 32'(signed'(cny));
  assign last_segment = segdone;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (cmd_valid) state_next = cmd.move ? BK_CALC : BK_WRITE;
      BK_CALC: state_next = BK_MUL;
      BK_MUL: state_next = BK_WRITE;
      BK_WRITE: begin
        if (!cur.move || (pt && segdone)) state_next = BK_EMIT;
        else state_next = BK_CALC;
      end
      BK_EMIT: if (pop && segdone) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    px = pt ? signed'(exs[seg]) : signed'(bxs[seg]);
    py = pt ? signed'(eys[seg]) : signed'(bys[seg]);
    rxw = (CW+20)'(pxc) - (CW+20)'(pys) + (CW+20)'(32768);
    ryw = (CW+20)'(pxs) + (CW+20)'(pyc) + (CW+20)'(32768);
    nx = CW'(rxw >>> 16) + CW'(signed'(cur.mx));
    ny = CW'(ryw >>> 16) + CW'(signed'(cur.my));
    vals[0] = -CW'(arm_length);
    vals[1] = -CW'(half_width);
    vals[2] = CW'(half_width);
    vals[3] = CW'(arm_length);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      seg <= '0;
      pt <= 1'b0;
      cnx <= '0;
      cny <= '0;
      for (int k = 0; k < SEG_COUNT; k++) begin
        bxs[k] <= '0;
        bys[k] <= '0;
        exs[k] <= '0;
        eys[k] <= '0;
      end
    end else begin
      state <= state_next;
      case (state)
        BK_IDLE: begin
          seg <= '0;
          pt <= 1'b0;
          if (cmd_valid) begin
            cur <= cmd;
            if (cmd.move) begin
              cnx <= cnx + CW'(signed'(cmd.mx));
              cny <= cny + CW'(signed'(cmd.my));
            end else begin
              cnx <= CW'(signed'(offset_x));
              cny <= CW'(signed'(offset_y));
            end
          end
        end
        BK_CALC: begin
          pxc <= px * signed'(cur.cos_v);
          pys <= py * signed'(cur.sin_v);
          pxs <= px * signed'(cur.sin_v);
          pyc <= py * signed'(cur.cos_v);
        end
        BK_WRITE: begin
          if (!cur.move) begin
            for (int k = 0; k < SEG_COUNT; k++) begin
              bxs[k] <= vals[2'(outline_code(4'(k)) >> 6)] + CW'(signed'(offset_x));
              bys[k] <= vals[2'(outline_code(4'(k)) >> 4)] + CW'(signed'(offset_y));
              exs[k] <= vals[2'(outline_code(4'(k)) >> 2)] + CW'(signed'(offset_x));
              eys[k] <= vals[2'(outline_code(4'(k)))] + CW'(signed'(offset_y));
            end
            seg <= '0;
          end else begin
            if (pt) begin
              exs[seg] <= nx;
              eys[seg] <= ny;
            end else begin
              bxs[seg] <= nx;
              bys[seg] <= ny;
            end
            pt <= !pt;
            if (pt) seg <= segdone ? '0 : seg + 1'b1;
          end
        end
        BK_EMIT: if (pop) seg <= segdone ? '0 : seg + 1'b1;
        default: ;
      endcase
    end
  end

  `ASSERT_IMPL(a_seg_range, clk, rst, 1'b1, seg < 4'(SEG_COUNT), "segment index out of range")
  `ASSERT_IMPL(a_take_idle, clk, rst, cmd_take, empty, "command taken while emitting")
  `ASSERT_IMPL(a_emit_phase, clk, rst, state == BK_EMIT, !pt, "endpoint phase left set")
endmodule
`default_nettype wire

[src/cross_obstacle_rigid_transform.sv]
// Top level: cross obstacle outline with rotate and translate.
// The front runs 16 CORDIC iterations per move item; the back end then takes each
// endpoint through calc, multiply and write states with one shared multiplier set,
// or rebuilds all segments at once, and emits 12 results, one per pop. A four-entry command
// queue lets the front work ahead. Sustained rate is bounded by the back end.
`default_nettype none
module cross_obstacle_rigid_transform
  import corx_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        action,
  input  wire logic [31:0] move_x,
  input  wire logic [31:0] move_y,
  input  wire logic [15:0] turn_angle,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       segment_index,
  output logic [31:0]      begin_x,
  output logic [31:0]      begin_y,
  output logic [31:0]      end_x,
  output logic [31:0]      end_y,
  output logic [31:0]      center_x,
  output logic [31:0]      center_y,
  output logic             last_segment
);
  logic [29:0] half_width, arm_length;
  logic [30:0] offset_x, offset_y;
  logic cmd_valid, cmd_take;
  cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= '0;
      arm_length <= '0;
      offset_x <= '0;
      offset_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_WIDTH: half_width <= cfg_data[29:0];
        REG_ARM_LENGTH: arm_length <= cfg_data[29:0];
        REG_OFFSET_X: offset_x <= cfg_data;
        REG_OFFSET_Y: offset_y <= cfg_data;
        default: ;
      endcase
    end
  end

  corx_front u_front (
    .clk, .rst, .push, .full, .action, .move_x, .move_y, .turn_angle,
    .cmd_valid, .cmd_take, .cmd
  );

  corx_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk, .rst, .cmd_valid, .cmd_take, .cmd, .half_width, .arm_length,
    .offset_x, .offset_y, .empty, .pop, .segment_index, .begin_x, .begin_y,
    .end_x, .end_y, .center_x, .center_y, .last_segment
  );
endmodule
`default_nettype wire

[test/cross_obstacle_rigid_transform_tb.sv]
// Testbench for the cross obstacle rigid transform: queued stimulus, predictor and checker.
module cross_obstacle_rigid_transform_tb;
  import corx_pkg::*;

  localparam int STALL_LIMIT = 20000;

  typedef struct {
    action_t     act;
    logic [31:0] mx;
    logic [31:0] my;
    logic [15:0] ang;
  } item_t;

  typedef struct {
    logic [3:0]  idx;
    logic [31:0] bx, by, ex, ey, cx, cy;
    logic        last;
  } seg_t;

  logic clk = 1'b0, rst = 1'b1;
  logic push = 1'b0, pop = 1'b0, full, empty;
  logic action = 1'b0;
  logic [31:0] move_x = '0, move_y = '0;
  logic [15:0] turn_angle = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic [3:0] segment_index;
  logic [31:0] begin_x, begin_y, end_x, end_y, center_x, center_y;
  logic last_segment;

  cross_obstacle_rigid_transform dut (.*);

  initial forever #2 clk = ~clk;

  // shadow of the block's registers and state
  logic [29:0] hw_r, al_r;
  logic [30:0] ox_r, oy_r;
  logic signed [31:0] outline [12][4];
  logic signed [31:0] ctr [2];

  item_t pending[$];
  seg_t  segs_due[$];
  int errors = 0;
  int push_gap = 0, pop_gap = 0;
  bit calm = 0;
  int idle_cycles = 0;

  const longint atan_tab [16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861};
  const logic [1:0] corner [12][4] = '{'{1,3,2,3}, '{2,3,2,2}, '{2,2,3,2}, '{3,2,3,1},
    '{3,1,2,1}, '{2,1,2,0}, '{2,0,1,0}, '{1,0,1,1}, '{1,1,0,1}, '{0,1,0,2},
    '{0,2,1,2}, '{1,2,1,3}};
  const logic [15:0] sweep_angles [12] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
    16'h3FFF, 16'h4001, 16'hBFFF, 16'hC001, 16'h2000, 16'hFFFF, 16'h0001, 16'h7FFF};

  task automatic trig(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] a;
    bit flip;
    longint x, y, z, dx, dy;
    a = {ang, 16'h0};
    flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    if (flip) a = a + 32'h8000_0000;
    z = longint'($signed(a));
    x = 652032875;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = (x + 8192) >>> 14;
    s = (y + 8192) >>> 14;
  endtask

  task automatic transform_outline(input item_t it);
    longint w, l, ox, oy, c, s, px, py, rx, ry;
    longint v [4];
    seg_t e;
    if (it.act == ACT_REBUILD) begin
      w = hw_r; l = al_r;
      ox = longint'($signed(ox_r)); oy = longint'($signed(oy_r));
      v[0] = -l; v[1] = -w; v[2] = w; v[3] = l;
      for (int k = 0; k < 12; k++)
        for (int j = 0; j < 4; j++)
          outline[k][j] = 32'(v[corner[k][j]] + ((j & 1) ? oy : ox));
      ctr[0] = 32'(ox);
      ctr[1] = 32'(oy);
    end else begin
      trig(it.ang, c, s);
      ctr[0] = ctr[0] + it.mx;
      ctr[1] = ctr[1] + it.my;
      for (int k = 0; k < 12; k++)
        for (int j = 0; j < 4; j += 2) begin
          px = outline[k][j]; py = outline[k][j+1];
          rx = (px * c - py * s + 32768) >>> 16;
          ry = (px * s + py * c + 32768) >>> 16;
          outline[k][j]   = 32'(rx) + it.mx;
          outline[k][j+1] = 32'(ry) + it.my;
        end
    end
    for (int k = 0; k < 12; k++) begin
      e.idx = 4'(k);
      e.bx = outline[k][0]; e.by = outline[k][1];
      e.ex = outline[k][2]; e.ey = outline[k][3];
      e.cx = ctr[0]; e.cy = ctr[1];
      e.last = (k == 11);
      segs_due.push_back(e);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  always @(posedge clk) begin
    item_t it;
    bit taken;
    taken = push && !full;
    if (taken) begin
      it.act = action_t'(action);
      it.mx = move_x; it.my = move_y; it.ang = turn_angle;
      transform_outline(it);
    end
    if (!rst && (!push || taken)) begin
      if (push_gap > 0) begin
        push_gap <= push_gap - 1;
        push <= 1'b0;
      end else if (pending.size() > 0) begin
        it = pending.pop_front();
        action <= it.act;
        move_x <= it.mx; move_y <= it.my; turn_angle <= it.ang;
        push <= 1'b1;
        push_gap <= pick_gap();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    seg_t e;
    if (!rst && pop && !empty) begin
      if (segs_due.size() == 0) begin
        $display("%0t: unexpected transfer, segment %0d", $time, segment_index);
        errors++;
      end else begin
        e = segs_due.pop_front();
        if ({segment_index, begin_x, begin_y, end_x, end_y, center_x, center_y,
             last_segment} !== {e.idx, e.bx, e.by, e.ex, e.ey, e.cx, e.cy, e.last}) begin
          $display("%0t: mismatch exp idx=%0d b=(%h,%h) e=(%h,%h) c=(%h,%h) last=%b",
                   $time, e.idx, e.bx, e.by, e.ex, e.ey, e.cx, e.cy, e.last);
          $display("%0t:          act idx=%0d b=(%h,%h) e=(%h,%h) c=(%h,%h) last=%b",
                   $time, segment_index, begin_x, begin_y, end_x, end_y, center_x,
                   center_y, last_segment);
          errors++;
        end
      end
    end
    if (!rst) begin
      if (pop_gap > 0) begin
        pop_gap <= pop_gap - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!pop || !empty) pop_gap <= pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** cross_obstacle_rigid_transform: FAILED **");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_HALF_WIDTH: hw_r = val[29:0];
      REG_ARM_LENGTH: al_r = val[29:0];
      REG_OFFSET_X:   ox_r = val;
      default:        oy_r = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [29:0] w, input logic [29:0] l,
                           input logic [30:0] x, input logic [30:0] y);
    write_reg(REG_HALF_WIDTH, {1'b0, w});
    write_reg(REG_ARM_LENGTH, {1'b0, l});
    write_reg(REG_OFFSET_X, x);
    write_reg(REG_OFFSET_Y, y);
  endtask

  task automatic add_item(input action_t a, input logic [31:0] mx, input logic [31:0] my,
                          input logic [15:0] ang);
    item_t it;
    it.act = a; it.mx = mx; it.my = my; it.ang = ang;
    pending.push_back(it);
  endtask

  task automatic add_random(input int n);
    logic [31:0] mx, my;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        mx = $urandom; my = $urandom;
      end else begin
        mx = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        my = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      end
      add_item($urandom_range(9) == 0 ? ACT_REBUILD : ACT_MOVE, mx, my, 16'($urandom));
    end
  endtask

  task automatic drain();
    do @(negedge clk); while (pending.size() > 0 || push || segs_due.size() > 0);
  endtask

  initial begin
    hw_r = '0; al_r = '0; ox_r = '0; oy_r = '0;
    for (int k = 0; k < 12; k++)
      for (int j = 0; j < 4; j++) outline[k][j] = '0;
    ctr[0] = '0; ctr[1] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // move before any rebuild, then the zero-size cross
    add_item(ACT_MOVE, 32'h0001_8000, 32'hFFFE_4000, 16'h1234);
    add_item(ACT_REBUILD, '0, '0, '0);
    add_item(ACT_MOVE, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000);
    drain();

    configure(30'h3FFF_FFFF, 30'h3FFF_FFFF, 31'h4000_0000, 31'h3FFF_FFFF);
    add_item(ACT_REBUILD, '0, '0, '0);
    add_item(ACT_MOVE, '0, '0, 16'h7FFF);
    add_item(ACT_MOVE, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000);
    drain();

    configure(30'h0001_0000, 30'h0005_0000, 31'h0002_0000, 31'h7FFD_0000);
    add_item(ACT_REBUILD, '0, '0, '0);
    foreach (sweep_angles[i])
      add_item(ACT_MOVE, 32'h0000_8000, 32'hFFFF_0000, sweep_angles[i]);
    add_item(ACT_MOVE, 32'hFFFF_FFFF, 32'h0000_0000, 16'h5555);
    add_item(ACT_MOVE, 32'h0000_0000, 32'hFFFF_FFFF, 16'hAAAA);
    drain();

    for (int p = 0; p < 8; p++) begin
      calm = (p == 3);
      if (p == 5) configure(30'h0, 30'h3FFF_FFFF, 31'h0, 31'h4000_0000);
      else configure(30'($urandom_range(0, 1 << 21)), 30'($urandom_range(0, 1 << 23)),
                     31'($urandom), 31'($urandom));
      add_item(ACT_REBUILD, '0, '0, '0);
      add_random(28);
      drain();
    end
    calm = 0;
    configure(30'($urandom), 30'($urandom), 31'($urandom), 31'($urandom));
    add_item(ACT_REBUILD, '0, '0, '0);
    add_random(4);
    drain();

    repeat (200) @(posedge clk);
    if (errors == 0 && segs_due.size() == 0) begin
      $display("** cross_obstacle_rigid_transform: PASSED **");
    end else begin
      $display("%0t: %0d mismatches, %0d results missing", $time, errors, segs_due.size());
      $display("** cross_obstacle_rigid_transform: FAILED **");
    end
    $finish;
  end
endmodule
